// File: rtl/lrs_pkg.sv
// Shared constants, codes and types for the label region statistics block.
// No dependencies; lrs_ctrl, lrs_dp and the top level import this package.
package lrs_pkg;

  localparam int MAX_LABELS = 32;
  localparam int IDX_W      = $clog2(MAX_LABELS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int IMAGE_DIM  = 256;
  localparam int DIM_W      = 9;
  localparam int BORDER_W   = 17;

  localparam logic [1:0] FUNC_PIXEL = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0]    DIM_RESET  = DIM_W'(IMAGE_DIM);
  localparam logic [BORDER_W-1:0] BORDER_MAX = '1;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] pixel_value;
    logic [7:0] up_value;
    logic [7:0] down_value;
    logic [7:0] left_value;
    logic [7:0] right_value;
    logic [7:0] pixel_row;
    logic [7:0] pixel_col;
    logic [4:0] entry_index;
  } in_item_t;

  typedef struct packed {
    logic                entry_valid;
    logic [7:0]          label_color;
    logic [7:0]          top_row;
    logic [7:0]          bottom_row;
    logic [7:0]          left_col;
    logic [7:0]          right_col;
    logic [BORDER_W-1:0] border_pixels;
    logic [8:0]          box_diameter;
    logic [7:0]          box_radius;
    logic [7:0]          centre_row;
    logic [7:0]          centre_col;
    logic                table_overflow;
  } out_item_t;

  // one table entry as held in the entry memory
  typedef struct packed {
    logic [7:0]          label;
    logic [7:0]          top;
    logic [7:0]          bottom;
    logic [7:0]          left;
    logic [7:0]          right;
    logic [BORDER_W-1:0] border;
  } ent_t;

  typedef struct packed {
    logic latch;       // capture the input beat
    logic clear;       // empty the table
    logic open;        // open a new entry for the latched label
    logic ovf_set;     // new label found no room
    logic rd_en;       // read the entry memory
    logic rd_sel_hit;  // read address: matched entry, else requested index
    logic upd;         // write back the widened entry
    logic load_out;    // load the result register
  } cmd_t;

  typedef struct packed {
    logic is_pixel;
    logic is_read;
    logic is_clear;
    logic bg;
    logic found;
    logic full;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/lrs_in_if.sv
// Input channel: valid/ready handshake carrying one pixel or request beat.
// No dependencies.
interface lrs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] pixel_value;
  logic [7:0] up_value;
  logic [7:0] down_value;
  logic [7:0] left_value;
  logic [7:0] right_value;
  logic [7:0] pixel_row;
  logic [7:0] pixel_col;
  logic [4:0] entry_index;

  modport source (
    output valid, func, pixel_value, up_value, down_value, left_value, right_value,
           pixel_row, pixel_col, entry_index,
    input  ready
  );
  modport sink (
    input  valid, func, pixel_value, up_value, down_value, left_value, right_value,
           pixel_row, pixel_col, entry_index,
    output ready
  );
endinterface

// File: rtl/lrs_out_if.sv
// Result channel: valid/ready handshake carrying one table entry read-out.
// No dependencies.
interface lrs_out_if;
  logic        valid;
  logic        ready;
  logic        entry_valid;
  logic [7:0]  label_color;
  logic [7:0]  top_row;
  logic [7:0]  bottom_row;
  logic [7:0]  left_col;
  logic [7:0]  right_col;
  logic [16:0] border_pixels;
  logic [8:0]  box_diameter;
  logic [7:0]  box_radius;
  logic [7:0]  centre_row;
  logic [7:0]  centre_col;
  logic        table_overflow;

  modport source (
    output valid, entry_valid, label_color, top_row, bottom_row, left_col, right_col,
           border_pixels, box_diameter, box_radius, centre_row, centre_col,
           table_overflow,
    input  ready
  );
  modport sink (
    input  valid, entry_valid, label_color, top_row, bottom_row, left_col, right_col,
           border_pixels, box_diameter, box_radius, centre_row, centre_col,
           table_overflow,
    output ready
  );
endinterface

// File: rtl/lrs_ctrl.sv
// Sequencing state machine: accepts a beat, then steers the datapath
// through look-up, memory read, write-back and result load. Uses lrs_pkg.
module lrs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  lrs_pkg::sts_t sts,
  output lrs_pkg::cmd_t cmd
);
  import lrs_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        state_nxt = S_IDLE;
        if (sts.is_clear) begin
          cmd.clear = 1'b1;
        end else if (sts.is_read) begin
          cmd.rd_en = 1'b1;
          state_nxt = S_OUT;
        end else if (sts.is_pixel && !sts.bg) begin
          if (sts.found) begin
            cmd.rd_en      = 1'b1;
            cmd.rd_sel_hit = 1'b1;
            state_nxt      = S_UPD;
          end else if (sts.full) begin
            cmd.ovf_set = 1'b1;
          end else begin
            cmd.open = 1'b1;
          end
        end
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_IDLE;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/lrs_dp.sv
// Datapath: config registers, label compare bank, entry memory, box and
// border update, result register. Uses lrs_pkg; driven by lrs_ctrl.
module lrs_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [8:0]          cfg_wdata,
  input  lrs_pkg::in_item_t   in_item,
  input  lrs_pkg::cmd_t       cmd,
  output lrs_pkg::sts_t       sts,
  output logic                out_valid,
  input  logic                out_ready,
  output lrs_pkg::out_item_t  out_item
);
  import lrs_pkg::*;

  logic [DIM_W-1:0] image_width_r;
  logic [DIM_W-1:0] image_height_r;
  in_item_t         item_r;
  logic [7:0]       labels_r [MAX_LABELS];
  logic [CNT_W-1:0] used_r;
  logic             ovf_r;
  logic [IDX_W-1:0] hit_idx_r;
  logic             border_r;
  logic             rd_valid_r;
  ent_t             mem [MAX_LABELS];
  ent_t             rd_data_r;
  out_item_t        out_r;
  logic             out_valid_r;

  logic [MAX_LABELS-1:0] match;
  logic [IDX_W-1:0]      hit_idx;
  logic                  border;
  logic [DIM_W-1:0]      last_row;
  logic [DIM_W-1:0]      last_col;
  logic [IDX_W-1:0]      rd_addr;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  ent_t                  wr_data;
  ent_t                  upd_ent;
  out_item_t             res;
  logic [8:0]            diam;
  logic [9:0]            diam_p1;
  logic [8:0]            row_sum;
  logic [8:0]            col_sum;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= DIM_RESET;
      image_height_r <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata;
        REG_IMAGE_HEIGHT: image_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= in_item;
    end
  end

  // label compare bank, masked by fill count
  always_comb begin
    hit_idx = '0;
    for (int k = 0; k < MAX_LABELS; k++) begin
      match[k] = (CNT_W'(k) < used_r) && (labels_r[k] == item_r.pixel_value);
    end
    for (int k = MAX_LABELS - 1; k >= 0; k--) begin
      if (match[k]) begin
        hit_idx = IDX_W'(k);
      end
    end
  end

  assign last_row = image_height_r - DIM_W'(1);
  assign last_col = image_width_r - DIM_W'(1);

  assign border = (item_r.pixel_row == 8'd0) || ({1'b0, item_r.pixel_row} == last_row)
               || (item_r.pixel_col == 8'd0) || ({1'b0, item_r.pixel_col} == last_col)
               || (item_r.up_value    != item_r.pixel_value)
               || (item_r.down_value  != item_r.pixel_value)
               || (item_r.left_value  != item_r.pixel_value)
               || (item_r.right_value != item_r.pixel_value);

  assign sts.is_pixel = (item_r.func == FUNC_PIXEL);
  assign sts.is_read  = (item_r.func == FUNC_READ);
  assign sts.is_clear = (item_r.func == FUNC_CLEAR);
  assign sts.bg       = (item_r.pixel_value == 8'd0);
  assign sts.found    = |match;
  assign sts.full     = (used_r == CNT_W'(MAX_LABELS));
  assign sts.out_free = !out_valid_r || out_ready;

  // table fill count, overflow flag and label bank
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      ovf_r  <= 1'b0;
    end else if (cmd.clear) begin
      used_r <= '0;
      ovf_r  <= 1'b0;
    end else begin
      if (cmd.open) begin
        used_r <= used_r + CNT_W'(1);
      end
      if (cmd.ovf_set) begin
        ovf_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.open) begin
      labels_r[used_r[IDX_W-1:0]] <= item_r.pixel_value;
    end
  end

  // entry memory: one registered read port, one write port
  assign rd_addr = cmd.rd_sel_hit ? hit_idx : IDX_W'(item_r.entry_index);

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r  <= mem[rd_addr];
      hit_idx_r  <= hit_idx;
      border_r   <= border;
      rd_valid_r <= (CNT_W'(item_r.entry_index) < used_r);
    end
  end

  always_comb begin
    upd_ent = rd_data_r;
    if (item_r.pixel_row < rd_data_r.top)    upd_ent.top    = item_r.pixel_row;
    if (item_r.pixel_row > rd_data_r.bottom) upd_ent.bottom = item_r.pixel_row;
    if (item_r.pixel_col < rd_data_r.left)   upd_ent.left   = item_r.pixel_col;
    if (item_r.pixel_col > rd_data_r.right)  upd_ent.right  = item_r.pixel_col;
    if (border_r && (rd_data_r.border != BORDER_MAX)) begin
      upd_ent.border = rd_data_r.border + BORDER_W'(1);
    end
  end

  always_comb begin
    wr_en   = cmd.open || cmd.upd;
    wr_addr = cmd.open ? used_r[IDX_W-1:0] : hit_idx_r;
    wr_data = upd_ent;
    if (cmd.open) begin
      wr_data.label  = item_r.pixel_value;
      wr_data.top    = item_r.pixel_row;
      wr_data.bottom = item_r.pixel_row;
      wr_data.left   = item_r.pixel_col;
      wr_data.right  = item_r.pixel_col;
      wr_data.border = border ? BORDER_W'(1) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // result formatting
  assign diam    = {1'b0, rd_data_r.right} - {1'b0, rd_data_r.left} + 9'd1;
  assign diam_p1 = {1'b0, diam} + 10'd1;
  assign row_sum = {1'b0, rd_data_r.top} + {1'b0, rd_data_r.bottom};
  assign col_sum = {1'b0, rd_data_r.left} + {1'b0, rd_data_r.right};

  always_comb begin
    res                = '0;
    res.table_overflow = ovf_r;
    if (rd_valid_r) begin
      res.entry_valid   = 1'b1;
      res.label_color   = rd_data_r.label;
      res.top_row       = rd_data_r.top;
      res.bottom_row    = rd_data_r.bottom;
      res.left_col      = rd_data_r.left;
      res.right_col     = rd_data_r.right;
      res.border_pixels = rd_data_r.border;
      res.box_diameter  = diam;
      res.box_radius    = diam_p1[8:1];
      res.centre_row    = row_sum[8:1];
      res.centre_col    = col_sum[8:1];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// File: rtl/label_region_statistics.sv
// Label region statistics, top level. One beat is taken, then worked on
// alone: clear, background, new label, overflow or unused code pass through
// the look-up state only; a box update of a known label adds a write-back
// state, set by the registered read of the entry memory. A read beat loads
// its result into the output register from the output state when that
// register is free, and holds in place while an earlier result waits. The
// next beat is taken while the loaded result waits.
// Reset empties the table by its fill count, clears the overflow flag and
// sets both image size registers to 256; no clearing pass is needed.
module label_region_statistics (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [8:0] cfg_wdata,
  lrs_in_if.sink     in_chan,
  lrs_out_if.source  out_chan
);
  import lrs_pkg::*;

  in_item_t  in_item;
  out_item_t out_item;
  cmd_t      cmd;
  sts_t      sts;
  logic      in_ready;
  logic      out_valid;

  assign in_item.func        = in_chan.func;
  assign in_item.pixel_value = in_chan.pixel_value;
  assign in_item.up_value    = in_chan.up_value;
  assign in_item.down_value  = in_chan.down_value;
  assign in_item.left_value  = in_chan.left_value;
  assign in_item.right_value = in_chan.right_value;
  assign in_item.pixel_row   = in_chan.pixel_row;
  assign in_item.pixel_col   = in_chan.pixel_col;
  assign in_item.entry_index = in_chan.entry_index;
  assign in_chan.ready       = in_ready;

  lrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lrs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .out_item  (out_item)
  );

  assign out_chan.valid          = out_valid;
  assign out_chan.entry_valid    = out_item.entry_valid;
  assign out_chan.label_color    = out_item.label_color;
  assign out_chan.top_row        = out_item.top_row;
  assign out_chan.bottom_row     = out_item.bottom_row;
  assign out_chan.left_col       = out_item.left_col;
  assign out_chan.right_col      = out_item.right_col;
  assign out_chan.border_pixels  = out_item.border_pixels;
  assign out_chan.box_diameter   = out_item.box_diameter;
  assign out_chan.box_radius     = out_item.box_radius;
  assign out_chan.centre_row     = out_item.centre_row;
  assign out_chan.centre_col     = out_item.centre_col;
  assign out_chan.table_overflow = out_item.table_overflow;

endmodule
